// ===== sv/kmhc_pkg.sv =====
package kmhc_pkg;

    // field widths of the item, result and config channels
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 16;
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_BASE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BREAK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_W-1:0] KMER_LEN_RESET = 4'd5;

    // nucleotide characters, both cases
    localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CH_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CH_T_LO = 8'h74;

    // 2-bit base codes
    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_G = 2'd1;
    localparam logic [1:0] CODE_C = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

endpackage

// ===== sv/kmhc_if.sv =====
interface kmhc_in_if;
    logic                          valid;
    logic                          ready;
    logic [kmhc_pkg::CMD_W-1:0]    cmd;
    logic [kmhc_pkg::CHAR_W-1:0]   base_char;
    logic [kmhc_pkg::IDX_W-1:0]    read_index;

    modport source (output valid, output cmd, output base_char, output read_index,
                    input ready);
    modport sink   (input valid, input cmd, input base_char, input read_index,
                    output ready);
endinterface

interface kmhc_out_if;
    logic                          valid;
    logic                          ready;
    logic                          counted;
    logic [kmhc_pkg::IDX_W-1:0]    kmer_code;
    logic [kmhc_pkg::VAL_W-1:0]    count_value;

    modport source (output valid, output counted, output kmer_code, output count_value,
                    input ready);
    modport sink   (input valid, input counted, input kmer_code, input count_value,
                    output ready);
endinterface

// ===== sv/kmhc_ram.sv =====
module kmhc_ram #(
    parameter int AW = 16,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read returns the old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/kmhc_window.sv =====
module kmhc_window #(
    parameter int MAX_K = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [kmhc_pkg::CMD_W-1:0]   i_cmd,
    input  logic [kmhc_pkg::CHAR_W-1:0]  i_base_char,
    input  logic [kmhc_pkg::CFG_W-1:0]   i_k_len,
    output logic                         o_hit,
    output logic [2*MAX_K-1:0]           o_index
);

    localparam int IW  = 2 * MAX_K;
    localparam int KW  = kmhc_pkg::CFG_W;
    localparam int RLW = $clog2(MAX_K + 1);
    localparam logic [KW-1:0]  MAX_K_C = KW'(MAX_K);
    localparam logic [RLW-1:0] MAX_RUN = RLW'(MAX_K);

    logic [IW-1:0]  r_win;
    logic [RLW-1:0] r_run;
    logic [IW-1:0]  n_win;
    logic [RLW-1:0] n_run;
    logic           w_valid;
    logic [1:0]     w_code;
    logic [KW-1:0]  w_k;
    logic [IW-1:0]  w_mask;

    always_comb begin
        w_valid = 1'b1;
        w_code  = kmhc_pkg::CODE_A;
        case (i_base_char) inside
            kmhc_pkg::CH_A_UP, kmhc_pkg::CH_A_LO: w_code = kmhc_pkg::CODE_A;
            kmhc_pkg::CH_G_UP, kmhc_pkg::CH_G_LO: w_code = kmhc_pkg::CODE_G;
            kmhc_pkg::CH_C_UP, kmhc_pkg::CH_C_LO: w_code = kmhc_pkg::CODE_C;
            kmhc_pkg::CH_T_UP, kmhc_pkg::CH_T_LO: w_code = kmhc_pkg::CODE_T;
            default: w_valid = 1'b0;
        endcase
    end

    // length 0 acts as 1, above the window as the window
    always_comb begin
        if (i_k_len == '0) begin
            w_k = KW'(1);
        end else if (i_k_len > MAX_K_C) begin
            w_k = MAX_K_C;
        end else begin
            w_k = i_k_len;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            w_mask[2*i +: 2] = (KW'(i) < w_k) ? 2'b11 : 2'b00;
        end
    end

    assign n_win   = IW'({r_win, w_code});
    assign n_run   = (r_run < MAX_RUN) ? r_run + RLW'(1) : r_run;
    assign o_hit   = (i_cmd == kmhc_pkg::CMD_BASE) && w_valid && (KW'(n_run) >= w_k);
    assign o_index = n_win & w_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_run <= '0;
        end else if (i_en) begin
            unique case (i_cmd)
                kmhc_pkg::CMD_BASE: begin
                    if (w_valid) begin
                        r_win <= n_win;
                        r_run <= n_run;
                    end else begin
                        r_run <= '0;
                    end
                end
                kmhc_pkg::CMD_BREAK: r_run <= '0;
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/kmer_histogram_counter_core.sv =====
// channel     | dir | handshake         | payload
// ------------+-----+-------------------+-------------------------------------
// i_item      | in  | valid/ready       | cmd, base_char, read_index
// o_result    | out | valid/ready       | counted, kmer_code, count_value
// i_cfg_wr_*  | in  | write enable only | k length (4 bits)
//
// one item per cycle sustained while the result side takes every transfer
// the result is registered after its input transfer, first in the registered
// read port of the counter memory, then in the result register; back-to-back
// hits on one counter are covered by a one-entry write forward
// after reset a sweep clears the counter memory, all 2**(2*MAX_K) entries
// (65536 at MAX_K = 8), with ready low; config writes are taken throughout
// a stalled result holds one item in the read stage, then ready drops
module kmer_histogram_counter_core #(
    parameter int MAX_K      = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [kmhc_pkg::CFG_W-1:0]  i_cfg_wr_data,
    kmhc_in_if.sink                     i_item,
    kmhc_out_if.source                  o_result
);

    localparam int IW = 2 * MAX_K;
    localparam int CW = COUNT_BITS;
    localparam int XW = kmhc_pkg::IDX_W;
    localparam int VW = kmhc_pkg::VAL_W;
    localparam logic [CW-1:0] CNT_MAX = '1;

    // what the read stage does with its item
    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_READ,
        KIND_COUNT
    } t_kind;

    // config register
    logic [kmhc_pkg::CFG_W-1:0] r_k_len;

    // clearing sweep
    logic          r_clearing;
    logic [IW-1:0] r_clr_addr;

    // read stage
    logic          r_s1_valid;
    t_kind         r_s1_kind;
    logic [IW-1:0] r_s1_addr;

    // last counter write, for forwarding
    logic          r_fwd_valid;
    logic [IW-1:0] r_fwd_addr;
    logic [CW-1:0] r_fwd_data;

    // result register
    logic          r_out_valid;
    logic          r_out_counted;
    logic [XW-1:0] r_out_code;
    logic [VW-1:0] r_out_value;

    logic          w_accept;
    logic          w_s1_move;
    logic          w_in_ready;
    logic          w_hit;
    logic [IW-1:0] w_win_index;
    t_kind         n_kind;
    logic [IW-1:0] n_addr;
    logic [CW-1:0] w_rd_data;
    logic [CW-1:0] w_cur;
    logic [CW-1:0] w_inc;
    logic          w_cnt_wr;
    logic          w_mem_wr;
    logic [IW-1:0] w_mem_waddr;
    logic [CW-1:0] w_mem_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_len <= kmhc_pkg::KMER_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_k_len <= i_cfg_wr_data;
        end
    end

    // read stage frees itself whenever the result register can take it
    assign w_s1_move  = r_s1_valid && (!r_out_valid || o_result.ready);
    assign w_in_ready = !r_clearing && (!r_s1_valid || w_s1_move);
    assign i_item.ready = w_in_ready;
    assign w_accept   = i_item.valid && w_in_ready;

    kmhc_window #(
        .MAX_K (MAX_K)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_accept),
        .i_cmd       (i_item.cmd),
        .i_base_char (i_item.base_char),
        .i_k_len     (r_k_len),
        .o_hit       (w_hit),
        .o_index     (w_win_index)
    );

    // classify the incoming item and pick the counter address
    always_comb begin
        n_kind = KIND_ZERO;
        n_addr = w_win_index;
        unique case (i_item.cmd)
            kmhc_pkg::CMD_BASE: n_kind = w_hit ? KIND_COUNT : KIND_ZERO;
            kmhc_pkg::CMD_READ: begin
                n_kind = KIND_READ;
                n_addr = IW'(i_item.read_index);
            end
            default: n_kind = KIND_ZERO;
        endcase
    end

    // the last write may have landed in the same cycle as this item's read
    assign w_cur = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : w_rd_data;
    // saturating increment
    assign w_inc = (w_cur == CNT_MAX) ? w_cur : w_cur + CW'(1);

    assign w_cnt_wr    = w_s1_move && (r_s1_kind == KIND_COUNT);
    assign w_mem_wr    = r_clearing || w_cnt_wr;
    assign w_mem_waddr = r_clearing ? r_clr_addr : r_s1_addr;
    assign w_mem_wdata = r_clearing ? '0 : w_inc;

    kmhc_ram #(
        .AW (IW),
        .DW (CW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_wr),
        .i_wr_addr (w_mem_waddr),
        .i_wr_data (w_mem_wdata),
        .i_rd_en   (w_accept),
        .i_rd_addr (n_addr),
        .o_rd_data (w_rd_data)
    );

    // clearing sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + IW'(1);
            if (&r_clr_addr) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_kind <= n_kind;
            r_s1_addr <= n_addr;
        end
    end

    // forward register tracks the latest counter write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (w_cnt_wr) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_wr) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= w_inc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            case (r_s1_kind)
                KIND_COUNT: begin
                    r_out_counted <= 1'b1;
                    r_out_code    <= XW'(r_s1_addr);
                    r_out_value   <= VW'(w_inc);
                end
                KIND_READ: begin
                    r_out_counted <= 1'b0;
                    r_out_code    <= XW'(r_s1_addr);
                    r_out_value   <= VW'(w_cur);
                end
                default: begin
                    r_out_counted <= 1'b0;
                    r_out_code    <= '0;
                    r_out_value   <= '0;
                end
            endcase
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.counted     = r_out_counted;
    assign o_result.kmer_code   = r_out_code;
    assign o_result.count_value = r_out_value;

endmodule

// ===== sv/kmhc_checker.sv =====
module kmhc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    logic w_in_xfer;

    assign w_in_xfer = i_in_valid && i_in_ready;

    // the clearing sweep keeps the input closed right after reset
    a_ready_low_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> !i_in_ready
    ) else $error("input ready high right after reset");

    // a rising result follows the input transfer that caused it, through the read stage and the result register
    a_result_follows_transfer: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_in_xfer, 2)
    ) else $error("result appeared without a matching input transfer");

    // a pending result stays until transferred
    a_result_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
    ) else $error("result dropped before transfer");

endmodule

bind kmer_histogram_counter_core kmhc_checker u_kmhc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready)
);
